[hw/rtl/gcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the weight table for the gradient color-ramp shader.
// No dependencies.
package gcs_pkg;
    localparam int MaxStops = 8;
    localparam int FracBits = 16;
    localparam int IdxW = $clog2(MaxStops);
    localparam int CntW = $clog2(MaxStops + 1);
    localparam int OffW = FracBits + 1;
    localparam logic [OffW-1:0] OneFx = OffW'(1) << FracBits;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SHADE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] FLT_NEAREST = 2'd0;
    localparam logic [1:0] FLT_GAUSS = 2'd2;
    localparam logic [1:0] EXT_REPEAT = 2'd1;
    localparam logic [1:0] EXT_REFLECT = 2'd2;

    localparam logic CFG_FILTER = 1'b0;
    localparam logic CFG_EXTEND = 1'b1;

    localparam logic [2:0] ST_PIXEL = 3'd0;
    localparam logic [2:0] ST_STORED = 3'd1;
    localparam logic [2:0] ST_NOPIX = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_EXT, S_SRCH, S_DIV, S_WGT, S_BLEND
    } t_state;

    typedef struct packed {
        logic            ins;
        logic [OffW-1:0] off;
        logic [31:0]     col;
    } t_ins;

    function automatic logic [16:0] gauss_tab(input logic [4:0] k);
        case (k)
            5'd0: gauss_tab = 17'd0;
            5'd1: gauss_tab = 17'd149;
            5'd2: gauss_tab = 17'd601;
            5'd3: gauss_tab = 17'd1365;
            5'd4: gauss_tab = 17'd2460;
            5'd5: gauss_tab = 17'd3913;
            5'd6: gauss_tab = 17'd5759;
            5'd7: gauss_tab = 17'd8046;
            5'd8: gauss_tab = 17'd10833;
            5'd9: gauss_tab = 17'd14195;
            5'd10: gauss_tab = 17'd18227;
            5'd11: gauss_tab = 17'd23046;
            5'd12: gauss_tab = 17'd28798;
            5'd13: gauss_tab = 17'd35665;
            5'd14: gauss_tab = 17'd43874;
            5'd15: gauss_tab = 17'd53712;
            default: gauss_tab = 17'd65536;
        endcase
    endfunction
endpackage

[hw/rtl/gcs_cell.sv]
`timescale 1ns / 1ps
// One stop cell: holds an offset and a color, shifts right on sorted insert,
// and flags when its segment holds the shade position. Uses gcs_pkg.
module gcs_cell import gcs_pkg::*; (
    input  logic            i_clk,
    input  logic [IdxW-1:0] i_idx,
    input  logic [CntW-1:0] i_count,
    input  t_ins            i_ins,
    input  logic [OffW-1:0] i_left_off,
    input  logic [31:0]     i_left_col,
    input  logic            i_left_move,
    input  logic [OffW-1:0] i_pos,
    output logic [OffW-1:0] o_off,
    output logic [31:0]     o_col,
    output logic            o_move,
    output logic            o_hit
);
    logic [OffW-1:0] r_off;
    logic [31:0]     r_col;
    logic            w_valid;

    assign w_valid = {1'b0, i_idx} < i_count;
    assign o_move = ({1'b0, i_idx} == i_count) || (w_valid && (r_off > i_ins.off));
    assign o_hit = (i_idx != '0) && w_valid && (i_pos <= r_off)
                   && ((i_idx == IdxW'(1)) || (i_pos > i_left_off));
    assign o_off = r_off;
    assign o_col = r_col;

    always_ff @(posedge i_clk) begin
        if (i_ins.ins && o_move) begin
            // take the left neighbor when it shifts too, else the new stop
            r_off <= i_left_move ? i_left_off : i_ins.off;
            r_col <= i_left_move ? i_left_col : i_ins.col;
        end
    end
endmodule

[hw/rtl/gcs_div.sv]
`timescale 1ns / 1ps
// Restoring divider for the segment fraction (d << 16) / w with d <= w.
// One quotient bit per cycle. Uses gcs_pkg.
module gcs_div import gcs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OffW-1:0] i_num,
    input  logic [OffW-1:0] i_den,
    output logic            o_done,
    output logic [OffW-1:0] o_quot
);
    localparam int StepW = $clog2(OffW + 1);
    logic [OffW:0]    r_rem;
    logic [OffW-1:0]  r_den;
    logic [OffW-1:0]  r_quot;
    logic [StepW-1:0] r_left;
    logic             r_done;
    logic             w_ge;
    logic [OffW:0]    w_sub;

    assign w_ge = r_rem >= {1'b0, r_den};
    assign w_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_left <= StepW'(OffW);
            end else if (r_left != '0) begin
                r_left <= r_left - StepW'(1);
                r_done <= (r_left == StepW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_left != '0) begin
            r_rem <= {w_sub[OffW-1:0], 1'b0};
            r_quot <= {r_quot[OffW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[hw/rtl/gradient_color_stop_shader.sv]
`timescale 1ns / 1ps
// Gradient color-ramp shader: sorted stop table of cells, extend, segment search,
// divider and blend. Uses gcs_pkg, gcs_cell, gcs_div.
//
// Usage: drive i_action and its fields with i_start; the item is taken at an
// edge where i_start is high and o_busy is low. Every item yields one beat on
// o_status / o_pixel_argb, marked by o_done for one cycle; the receiver cannot
// stall it, so it must take each beat as it comes.
// Add-stop, clear and unused codes raise o_done in the next cycle, and o_busy stays low.
// A shade item runs through extend and clamp, the segment search across the stop
// cells, the one-bit-a-cycle divider (17 quotient steps and its done flag), the
// gaussian weight, and the blend into the result register. A shade with fewer
// than two stops is answered from idle without going busy; one with a zero-width
// segment ends after the search state.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_wdata) must be written only while idle;
// the block does not enforce it. Index 0 filter mode, index 1 extend mode.
// Reset empties the stop table, sets linear filtering and no extend; stop
// contents are undefined until written.
module gradient_color_stop_shader import gcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [16:0] i_stop_offset,
    input  logic [7:0]  i_stop_red,
    input  logic [7:0]  i_stop_green,
    input  logic [7:0]  i_stop_blue,
    input  logic [7:0]  i_stop_alpha,
    input  logic signed [31:0] i_position,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_pixel_argb
);
    t_state r_state, n_state;
    logic [1:0]      r_filter, r_extend;
    logic [CntW-1:0] r_count, n_count;
    logic signed [31:0] r_pos;
    logic [OffW-1:0] r_p, n_p;
    logic [OffW-1:0] r_lo, r_hi, r_t, r_g, n_g;
    logic [31:0]     r_c0, r_c1;
    logic            r_done, n_done;
    logic [2:0]      r_status, n_status;
    logic [31:0]     r_pixel, n_pixel;
    logic            w_accept, w_div_start, w_div_done;
    logic [OffW-1:0] w_quot;
    t_ins            w_ins;

    logic [OffW-1:0] w_off [MaxStops];
    logic [31:0]     w_col [MaxStops];
    logic [MaxStops-1:0] w_move, w_hit;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    assign w_ins.ins = w_accept && (i_action == ACT_ADD) && (r_count < CntW'(MaxStops));
    assign w_ins.off = (i_stop_offset > OneFx) ? OneFx : i_stop_offset;
    assign w_ins.col = {i_stop_alpha, i_stop_red, i_stop_green, i_stop_blue};

    for (genvar k = 0; k < MaxStops; k++) begin : g_cell
        gcs_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (IdxW'(k)),
            .i_count     (r_count),
            .i_ins       (w_ins),
            .i_left_off  ((k == 0) ? '0 : w_off[(k == 0) ? 0 : k-1]),
            .i_left_col  ((k == 0) ? '0 : w_col[(k == 0) ? 0 : k-1]),
            .i_left_move ((k == 0) ? 1'b0 : w_move[(k == 0) ? 0 : k-1]),
            .i_pos       (r_p),
            .o_off       (w_off[k]),
            .o_col       (w_col[k]),
            .o_move      (w_move[k]),
            .o_hit       (w_hit[k])
        );
    end

    // segment select: the hit cell is the upper stop, its left neighbor the lower
    logic [OffW-1:0] w_slo, w_shi;
    logic [31:0]     w_sc0, w_sc1;
    always_comb begin
        w_slo = '0; w_shi = '0; w_sc0 = '0; w_sc1 = '0;
        for (int k = 1; k < MaxStops; k++) begin
            if (w_hit[k]) begin
                w_slo = w_slo | w_off[k-1];
                w_shi = w_shi | w_off[k];
                w_sc0 = w_sc0 | w_col[k-1];
                w_sc1 = w_sc1 | w_col[k];
            end
        end
    end

    // extend and clamp
    logic             w_neg, w_out, w_odd;
    logic [32:0]      w_abs;
    logic [FracBits-1:0] w_frac;
    logic [OffW-1:0]  w_refl;
    logic signed [32:0] w_pe;
    logic [OffW-1:0]  w_first, w_last;
    always_comb begin
        w_neg = r_pos[31];
        w_out = w_neg || (r_pos > $signed({15'd0, OneFx}));
        w_abs = w_neg ? (33'd0 - {r_pos[31], r_pos}) : {1'b0, r_pos};
        w_odd = w_abs[FracBits];
        w_frac = r_pos[FracBits-1:0];
        w_refl = (w_odd ^ w_neg) ? (OneFx - {1'b0, w_frac}) : {1'b0, w_frac};
        w_pe = {r_pos[31], r_pos};
        if (w_out && (r_extend == EXT_REPEAT)) begin
            w_pe = $signed({16'd0, 1'b0, w_frac});
        end else if (w_out && (r_extend == EXT_REFLECT)) begin
            w_pe = $signed({16'd0, w_refl});
        end
        w_first = w_off[0];
        w_last = w_off[IdxW'(r_count - CntW'(1))];
        n_p = w_pe[OffW-1:0];
        if (w_pe < $signed({16'd0, w_first})) begin
            n_p = w_first;
        end else if (w_pe > $signed({16'd0, w_last})) begin
            n_p = w_last;
        end
    end

    assign w_div_start = (r_state == S_SRCH) && (w_shi != w_slo);

    gcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_p - w_slo),
        .i_den   (w_shi - w_slo),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // gaussian weight between table entries
    logic [4:0]  w_gk;
    logic [11:0] w_grem;
    logic [16:0] w_glo, w_ghi;
    logic [28:0] w_gprod;
    always_comb begin
        w_gk = r_t[OffW-1:FracBits-4];
        w_grem = r_t[FracBits-5:0];
        w_glo = gauss_tab(w_gk);
        w_ghi = gauss_tab(w_gk + 5'd1);
        w_gprod = (w_ghi - w_glo) * w_grem;
        n_g = (w_gk >= 5'd16) ? gauss_tab(5'd16) : (w_glo + w_gprod[28:12]);
    end

    // blend
    logic [OffW-1:0] w_wt;
    logic [31:0]     w_blend;
    logic [7:0]      w_a, w_b;
    logic [25:0]     w_mix;
    always_comb begin
        w_wt = (r_filter == FLT_GAUSS) ? r_g : r_t;
        w_blend = '0;
        for (int c = 0; c < 4; c++) begin
            w_a = r_c0[c*8 +: 8];
            w_b = r_c1[c*8 +: 8];
            w_mix = w_b * w_wt + w_a * (OneFx - w_wt);
            if (r_filter == FLT_NEAREST) begin
                w_blend[c*8 +: 8] = (r_t < (OneFx >> 1)) ? w_a : w_b;
            end else begin
                w_blend[c*8 +: 8] = w_mix[23:16];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done = 1'b0;
        n_status = r_status;
        n_pixel = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done = 1'b1;
                    n_status = ST_NOPIX;
                    case (i_action)
                        ACT_ADD: begin
                            if (w_ins.ins) begin
                                n_count = r_count + CntW'(1);
                                n_status = ST_STORED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        ACT_SHADE: begin
                            if (r_count >= CntW'(2)) begin
                                n_done = 1'b0;
                                n_state = S_EXT;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_status = ST_CLEARED;
                        end
                        default: n_status = ST_NOPIX;
                    endcase
                end
            end
            S_EXT: n_state = S_SRCH;
            S_SRCH: begin
                if (w_shi == w_slo) begin
                    n_done = 1'b1;
                    n_status = ST_NOPIX;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: if (w_div_done) n_state = S_WGT;
            S_WGT: n_state = S_BLEND;
            S_BLEND: begin
                n_done = 1'b1;
                n_status = ST_PIXEL;
                n_pixel = w_blend;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done <= 1'b0;
            r_filter <= 2'd1;
            r_extend <= 2'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done <= n_done;
            if (i_cfg_we && (i_cfg_idx == CFG_FILTER)) r_filter <= i_cfg_wdata;
            if (i_cfg_we && (i_cfg_idx == CFG_EXTEND)) r_extend <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pixel <= n_pixel;
        if (w_accept) r_pos <= i_position;
        if (r_state == S_EXT) r_p <= n_p;
        if (r_state == S_SRCH) begin
            r_lo <= w_slo;
            r_hi <= w_shi;
            r_c0 <= w_sc0;
            r_c1 <= w_sc1;
        end
        if (w_div_done) r_t <= (w_quot > OneFx) ? OneFx : w_quot;
        if (r_state == S_WGT) r_g <= n_g;
    end

    assign o_done = r_done;
    assign o_status = r_status;
    assign o_pixel_argb = r_pixel;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result beat while busy");
    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_PIXEL)) |-> (o_pixel_argb == '0))
        else $error("pixel set without pixel status");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxStops)) else $error("stop count overflow");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_done || o_busy)) else $error("accepted item dropped");
    a_seg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_lo < r_hi)) else $error("bad segment");
endmodule
